// ===== rtl/srfp_pkg.sv =====
package srfp_pkg;

   localparam int WIN_DEPTH = 9;
   localparam int FILL_W    = 4;

   localparam logic [7:0] START_MARK = 8'hAA;
   localparam logic [7:0] END_MARK   = 8'hFF;
   localparam logic [7:0] AD_REPLY   = 8'hA1;
   localparam logic [7:0] SIGN_NEG   = 8'h01;

   localparam int READING_W = 25;
   localparam int RSP_W     = 48;

   // window taps, index 0 oldest; full means all nine taps hold received bytes
   typedef struct packed {
      logic [WIN_DEPTH-1:0][7:0] taps;
      logic                      full;
   } window_type;

   // one decoded reply; packed so that frame_ok sits in the lowest bit
   typedef struct packed {
      logic signed [READING_W-1:0] reading;
      logic                        negative_flag;
      logic [7:0]                  module_address;
      logic [7:0]                  reply_command;
      logic                        frame_ok;
   } result_type;

   typedef struct packed {
      logic       hit;
      result_type result;
   } decode_type;

endpackage

// ===== rtl/srfp_window.sv =====
module srfp_window
   import srfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift,
   input  logic       clear,
   input  logic [7:0] rx_byte,
   output window_type window
);

   logic [WIN_DEPTH-1:0][7:0] taps_ff;
   logic [FILL_W-1:0]         fill_ff;
   logic [FILL_W-1:0]         fill_in;

   // shift toward the oldest tap, newest byte enters at the top
   always_ff @(posedge clock) begin
      if (shift) begin
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            taps_ff[i] <= taps_ff[i+1];
         end
         taps_ff[WIN_DEPTH-1] <= rx_byte;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (clear) begin
         fill_in = '0;
      end else if (shift && (fill_ff != FILL_W'(WIN_DEPTH))) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign window.taps = taps_ff;
   assign window.full = (fill_ff == FILL_W'(WIN_DEPTH));

endmodule

// ===== rtl/srfp_decode.sv =====
module srfp_decode
   import srfp_pkg::*;
(
   input  window_type window,
   input  logic [7:0] rx_byte,
   output decode_type decode
);

   logic [15:0]          sum;
   logic [15:0]          given;
   logic [23:0]          mag;
   logic                 neg;
   logic [READING_W-1:0] mag_ext;

   always_comb begin
      sum = 16'(window.taps[1]) + 16'(window.taps[2]) + 16'(window.taps[3])
          + 16'(window.taps[4]) + 16'(window.taps[5]) + 16'(window.taps[6]);
      given   = {window.taps[7], window.taps[8]};
      mag     = {window.taps[4], window.taps[5], window.taps[6]};
      mag_ext = {1'b0, mag};
      neg     = (window.taps[1] != AD_REPLY) && (window.taps[3] == SIGN_NEG);

      decode.hit = window.full && (window.taps[0] == START_MARK) && (rx_byte == END_MARK);
      decode.result = '0;
      if (sum == given) begin
         decode.result.frame_ok       = 1'b1;
         decode.result.reply_command  = window.taps[1];
         decode.result.module_address = window.taps[2];
         decode.result.negative_flag  = neg;
         decode.result.reading        = neg ? -mag_ext : mag_ext;
      end
   end

endmodule

// ===== rtl/scale_reply_frame_parser_top.sv =====
// Reply frame parser for a serial weighing sensor module. Received bytes enter
// one word per cycle on the req_ stream; the block keeps the last nine bytes and
// recognizes a ten-byte frame when the oldest held byte is 0xAA and the new byte
// is 0xFF. For a frame it sends one rsp_ word: on a matching checksum (16-bit sum
// of bytes 1..6 against bytes 7..8, big-endian) frame_ok is 1 with command,
// address, sign and a signed 25-bit reading (byte 3 equal to 1 marks negative,
// except for the raw AD reply 0xA1); on a mismatch frame_ok is 0 and all other
// fields are 0. Either way the window is emptied and the closing 0xFF is not
// kept. Bytes that close no frame produce no word. A byte is taken every cycle
// unless a stalled reply holds it up; a reply is presented once its closing byte,
// held in the input register, moves on and the reply loads into the result
// register. A reply stalled on rsp_tready holds up only a byte that closes
// another frame behind it.
module scale_reply_frame_parser_top
   import srfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,  // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // [0] frame_ok, [8:1] reply_command,
                                        // [16:9] module_address, [17] negative_flag,
                                        // [42:18] reading, [47:43] zero
);

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [7:0] s1_byte_ff;

   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   window_type window;
   decode_type decode;

   logic out_free;
   logic s1_advance;
   logic rsp_load;

   // decide on the held byte against the current window
   srfp_decode u_decode (
      .window  (window),
      .rx_byte (s1_byte_ff),
      .decode  (decode)
   );

   // result register empties this cycle or is already empty
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // a byte without a frame always moves on; a frame waits for room
   assign s1_advance = s1_valid_ff && (!decode.hit || out_free);
   assign rsp_load   = s1_advance && decode.hit;
   assign req_tready = !s1_valid_ff || s1_advance;

   // append a plain byte, drop the whole window on a frame
   srfp_window u_window (
      .clock   (clock),
      .reset   (reset),
      .shift   (s1_advance && !decode.hit),
      .clear   (rsp_load),
      .rx_byte (s1_byte_ff),
      .window  (window)
   );

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= decode.result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - $bits(result_type))'(0), rsp_data_ff};

`ifndef ASSERT_OFF
   // an error reply carries nothing but the cleared flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[RSP_W-1:1] == '0)
      else $error("error reply with nonzero fields");

   // the raw AD reply never carries a sign
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tdata[8:1] != AD_REPLY)
      else $error("negative flag on AD reply");

   // a recognized frame empties the window
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> !window.full)
      else $error("window not cleared after frame");

   // a frame is never dropped: the result register must have room when loaded
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("reply overwritten");
`endif

endmodule
